/* rtl/tpfc_pkg.sv */
// ----------------------------------------------------------------------------
// Texture pixel format converter package
// Format codes, configuration register indexes, luma constants and the
// per-stage pixel payload type.
// ----------------------------------------------------------------------------
package tpfc_pkg;

    typedef enum logic [2:0] {
        FMT_I8       = 3'd0,
        FMT_AI88     = 3'd1,
        FMT_RGB888   = 3'd2,
        FMT_RGBA8888 = 3'd3,
        FMT_RGB565   = 3'd4,
        FMT_A8       = 3'd5,
        FMT_RGBA4444 = 3'd6,
        FMT_RGB5A1   = 3'd7
    } fmt_t;

    localparam int unsigned SRC_FMT_W  = 2;
    localparam int unsigned TGT_FMT_W  = 4;
    localparam int unsigned CFG_DATA_W = 4;
    localparam int unsigned CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_SRC_FMT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TGT_FMT = 1'b1;

    localparam logic [SRC_FMT_W-1:0] SRC_FMT_RESET = 2'd3;
    localparam logic [TGT_FMT_W-1:0] TGT_FMT_RESET = 4'd8;

    // Luma weights, rounding term and reciprocal of 1000 scaled by 2^28
    localparam int unsigned LUMA_WR     = 299;
    localparam int unsigned LUMA_WG     = 587;
    localparam int unsigned LUMA_WB     = 114;
    localparam int unsigned LUMA_ROUND  = 500;
    localparam int unsigned LUMA_SHIFT  = 28;
    localparam int unsigned LUMA_RECIP  = (1 << LUMA_SHIFT) / 1000 + 1;
    localparam int unsigned LUMA_SUM_W  = 18;
    localparam int unsigned LUMA_PROD_W = 37;

    localparam int unsigned PIPE_DEPTH = 3;

    typedef struct packed {
        logic [7:0] c0;
        logic [7:0] c1;
        logic [7:0] c2;
        logic [7:0] c3;
        logic       last;
    } side_t;

endpackage

/* rtl/tpfc_src_if.sv */
// ----------------------------------------------------------------------------
// Source pixel channel
// Valid/ready channel carrying up to four source bytes and the end marker.
// ----------------------------------------------------------------------------
interface tpfc_src_if;
    logic       valid;
    logic       ready;
    logic [7:0] chan0;
    logic [7:0] chan1;
    logic [7:0] chan2;
    logic [7:0] chan3;
    logic       last_in;

    modport source (output valid, chan0, chan1, chan2, chan3, last_in, input ready);
    modport sink   (input valid, chan0, chan1, chan2, chan3, last_in, output ready);
endinterface

/* rtl/tpfc_dst_if.sv */
// ----------------------------------------------------------------------------
// Converted pixel channel
// Valid/ready channel carrying the packed pixel, byte count and format.
// ----------------------------------------------------------------------------
interface tpfc_dst_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_pixel;
    logic [2:0]  out_bytes;
    logic [2:0]  out_format;
    logic        last_out;

    modport source (output valid, out_pixel, out_bytes, out_format, last_out, input ready);
    modport sink   (input valid, out_pixel, out_bytes, out_format, last_out, output ready);
endinterface

/* rtl/texture_pixel_format_converter.sv */
// ----------------------------------------------------------------------------
// Texture pixel format converter
// Converts one pixel per beat from the configured source format to the
// configured target format, packed first byte lowest.
// ----------------------------------------------------------------------------
// Takes one pixel per clock and passes it through the luma path (products,
// sum, reciprocal multiply) and then the packing stage that feeds the output
// register. The whole pipeline advances together whenever the output register
// is empty or being taken, so a stall at the sink holds every stage. Source
// and target formats come from two registers that the user must write through
// the cfg port only while no pixel is in flight; the block does not enforce
// this. A pair that cannot be converted returns the source bytes and format.
module texture_pixel_format_converter (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [tpfc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tpfc_pkg::CFG_DATA_W-1:0]  cfg_data,
    tpfc_src_if.sink                         src,
    tpfc_dst_if.source                       dst
);
    import tpfc_pkg::*;

    logic [SRC_FMT_W-1:0] src_fmt_reg;
    logic [TGT_FMT_W-1:0] tgt_fmt_reg;

    logic                  adv;
    logic [PIPE_DEPTH-1:0] vld_reg;
    side_t                 side_reg [PIPE_DEPTH];
    side_t                 side_in;
    side_t                 s;
    logic [7:0]            luma_y;

    fmt_t        src_fmt;
    fmt_t        tgt_fmt;
    logic        has_a8;
    logic        mono;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [7:0]  a;
    logic [7:0]  y;
    logic        conv_ok;
    logic [31:0] conv_pixel;
    logic [2:0]  conv_bytes;

    logic        out_vld_reg;
    logic [31:0] out_pixel_reg;
    logic [31:0] out_pixel_next;
    logic [2:0]  out_bytes_reg;
    logic [2:0]  out_bytes_next;
    logic [2:0]  out_format_reg;
    logic [2:0]  out_format_next;
    logic        last_out_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_fmt_reg <= SRC_FMT_RESET;
            tgt_fmt_reg <= TGT_FMT_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_SRC_FMT)
                src_fmt_reg <= cfg_data[SRC_FMT_W-1:0];
            else if (cfg_index == CFG_TGT_FMT)
                tgt_fmt_reg <= cfg_data[TGT_FMT_W-1:0];
        end
    end

    // Pipeline control: advance all stages together unless the output is held
    assign adv       = !out_vld_reg || dst.ready;
    assign src.ready = adv;

    assign side_in.c0   = src.chan0;
    assign side_in.c1   = src.chan1;
    assign side_in.c2   = src.chan2;
    assign side_in.c3   = src.chan3;
    assign side_in.last = src.last_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg     <= {vld_reg[PIPE_DEPTH-2:0], src.valid};
            out_vld_reg <= vld_reg[PIPE_DEPTH-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= side_in;
            for (int i = 1; i < PIPE_DEPTH; i++)
                side_reg[i] <= side_reg[i-1];
            out_pixel_reg  <= out_pixel_next;
            out_bytes_reg  <= out_bytes_next;
            out_format_reg <= out_format_next;
            last_out_reg   <= side_reg[PIPE_DEPTH-1].last;
        end
    end

    tpfc_luma u_luma (
        .clk (clk),
        .adv (adv),
        .r   (src.chan0),
        .g   (src.chan1),
        .b   (src.chan2),
        .y   (luma_y)
    );

    // Unify the source, convert, fall back to the source bytes
    assign s       = side_reg[PIPE_DEPTH-1];
    assign src_fmt = fmt_t'({1'b0, src_fmt_reg});
    assign tgt_fmt = fmt_t'(tgt_fmt_reg[2:0]);
    assign has_a8  = (src_fmt == FMT_AI88) || (src_fmt == FMT_RGBA8888);
    assign mono    = (src_fmt == FMT_I8) || (src_fmt == FMT_AI88);
    assign r       = s.c0;
    assign g       = mono ? s.c0 : s.c1;
    assign b       = mono ? s.c0 : s.c2;
    assign y       = mono ? s.c0 : luma_y;

    always_comb
    begin
        case (src_fmt)
            FMT_AI88:     a = s.c1;
            FMT_RGBA8888: a = s.c3;
            default:      a = 8'hFF;
        endcase
    end

    always_comb
    begin
        conv_ok    = !tgt_fmt_reg[3] && (tgt_fmt != src_fmt);
        conv_pixel = '0;
        conv_bytes = 3'd0;
        case (tgt_fmt)
            FMT_I8:
            begin
                conv_pixel = {24'd0, y};
                conv_bytes = 3'd1;
            end
            FMT_AI88:
            begin
                conv_pixel = {16'd0, a, y};
                conv_bytes = 3'd2;
            end
            FMT_RGB888:
            begin
                conv_pixel = {8'd0, b, g, r};
                conv_bytes = 3'd3;
            end
            FMT_RGBA8888:
            begin
                conv_pixel = {a, b, g, r};
                conv_bytes = 3'd4;
            end
            FMT_RGB565:
            begin
                conv_pixel = {16'd0, r[7:3], g[7:2], b[7:3]};
                conv_bytes = 3'd2;
            end
            FMT_A8:
            begin
                if (!has_a8)
                    conv_ok = 1'b0;
                conv_pixel = {24'd0, a};
                conv_bytes = 3'd1;
            end
            FMT_RGBA4444:
            begin
                conv_pixel = {16'd0, r[7:4], g[7:4], b[7:4], a[7:4]};
                conv_bytes = 3'd2;
            end
            FMT_RGB5A1:
            begin
                conv_pixel = {16'd0, r[7:3], g[7:3], b[7:3], a[7]};
                conv_bytes = 3'd2;
            end
            default:
            begin
                conv_ok = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_pixel_next  = conv_pixel;
        out_bytes_next  = conv_bytes;
        out_format_next = tgt_fmt;
        if (!conv_ok)
        begin
            out_format_next = src_fmt;
            case (src_fmt)
                FMT_I8:
                begin
                    out_pixel_next = {24'd0, s.c0};
                    out_bytes_next = 3'd1;
                end
                FMT_AI88:
                begin
                    out_pixel_next = {16'd0, s.c1, s.c0};
                    out_bytes_next = 3'd2;
                end
                FMT_RGB888:
                begin
                    out_pixel_next = {8'd0, s.c2, s.c1, s.c0};
                    out_bytes_next = 3'd3;
                end
                default:
                begin
                    out_pixel_next = {s.c3, s.c2, s.c1, s.c0};
                    out_bytes_next = 3'd4;
                end
            endcase
        end
    end

    assign dst.valid      = out_vld_reg;
    assign dst.out_pixel  = out_pixel_reg;
    assign dst.out_bytes  = out_bytes_reg;
    assign dst.out_format = out_format_reg;
    assign dst.last_out   = last_out_reg;

    // Accepted beat enters the first stage
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        src.valid && src.ready |=> vld_reg[0])
        else $error("accepted beat did not enter the pipeline");

    // Held output freezes every stage
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg) && $stable(out_vld_reg))
        else $error("pipeline moved during a stall");

    // Byte count in range and bytes above it zero
    a_bytes_packed: assert property (@(posedge clk) disable iff (!rst_n)
        dst.valid |-> (out_bytes_reg == 3'd1 && out_pixel_reg[31:8] == 24'd0)
                   || (out_bytes_reg == 3'd2 && out_pixel_reg[31:16] == 16'd0)
                   || (out_bytes_reg == 3'd3 && out_pixel_reg[31:24] == 8'd0)
                   || (out_bytes_reg == 3'd4))
        else $error("byte count and packed pixel disagree");

    // Last stage beat reaches the output register when the pipeline advances
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        adv && vld_reg[PIPE_DEPTH-1] |=> out_vld_reg)
        else $error("last stage beat lost");

endmodule

/* rtl/tpfc_luma.sv */
// ----------------------------------------------------------------------------
// Luma pipeline
// Three-stage (R*299 + G*587 + B*114 + 500) / 1000: weighted products,
// sum, then reciprocal multiply with the quotient taken from the high bits.
// ----------------------------------------------------------------------------
module tpfc_luma (
    input  logic       clk,
    input  logic       adv,
    input  logic [7:0] r,
    input  logic [7:0] g,
    input  logic [7:0] b,
    output logic [7:0] y
);
    import tpfc_pkg::*;

    logic [16:0]            pr_reg;
    logic [17:0]            pg_reg;
    logic [14:0]            pb_reg;
    logic [LUMA_SUM_W-1:0]  sum_reg;
    logic [LUMA_SUM_W-1:0]  sum_next;
    logic [LUMA_PROD_W-1:0] prod;
    logic [7:0]             y_reg;

    assign sum_next = LUMA_SUM_W'(pr_reg) + LUMA_SUM_W'(pg_reg) + LUMA_SUM_W'(pb_reg)
                    + LUMA_SUM_W'(LUMA_ROUND);
    assign prod     = LUMA_PROD_W'(sum_reg) * LUMA_PROD_W'(LUMA_RECIP);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pr_reg  <= 17'(r) * 17'(LUMA_WR);
            pg_reg  <= 18'(g) * 18'(LUMA_WG);
            pb_reg  <= 15'(b) * 15'(LUMA_WB);
            sum_reg <= sum_next;
            y_reg   <= prod[LUMA_SHIFT+7:LUMA_SHIFT];
        end
    end

    assign y = y_reg;

endmodule

/* sim/tpfc_pixel_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel conversion checker
// Tracks the format registers from the cfg port, predicts the converted pixel
// for every source beat and compares each output beat with the oldest
// prediction, field by field.
// ----------------------------------------------------------------------------
module tpfc_pixel_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [tpfc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tpfc_pkg::CFG_DATA_W-1:0] cfg_data,
    tpfc_src_if                             src,
    tpfc_dst_if                             dst,
    output int                              fail_count,
    output int                              pending
);
    import tpfc_pkg::*;

    localparam int unsigned LUMA_DIV = 1000;

    typedef struct packed {
        logic [31:0] pixel;
        logic [2:0]  nbytes;
        fmt_t        format;
        logic        last;
    } pixel_result_t;

    logic [SRC_FMT_W-1:0] src_fmt_q;
    logic [TGT_FMT_W-1:0] tgt_fmt_q;
    pixel_result_t        converted_q[$];
    int                   errors = 0;

    function automatic pixel_result_t convert_pixel(
        input logic [SRC_FMT_W-1:0] src_code,
        input logic [TGT_FMT_W-1:0] tgt_code,
        input logic [7:0]           c0,
        input logic [7:0]           c1,
        input logic [7:0]           c2,
        input logic [7:0]           c3,
        input logic                 last
    );
        pixel_result_t res;
        fmt_t          src_fmt;
        fmt_t          tgt_fmt;
        logic [7:0]    r, g, b, a, y;
        logic          has_a8;
        logic          ok;
        int unsigned   sum;

        src_fmt = fmt_t'({1'b0, src_code});
        tgt_fmt = fmt_t'(tgt_code[2:0]);
        r = c0;
        case (src_fmt)
            FMT_I8:
            begin
                g      = c0;
                b      = c0;
                a      = 8'hFF;
                has_a8 = 1'b0;
            end
            FMT_AI88:
            begin
                g      = c0;
                b      = c0;
                a      = c1;
                has_a8 = 1'b1;
            end
            FMT_RGB888:
            begin
                g      = c1;
                b      = c2;
                a      = 8'hFF;
                has_a8 = 1'b0;
            end
            default:
            begin
                g      = c1;
                b      = c2;
                a      = c3;
                has_a8 = 1'b1;
            end
        endcase
        sum = int'(r) * LUMA_WR + int'(g) * LUMA_WG + int'(b) * LUMA_WB + LUMA_ROUND;
        y = (src_fmt == FMT_I8 || src_fmt == FMT_AI88) ? c0 : 8'(sum / LUMA_DIV);

        ok = !tgt_code[3] && (tgt_fmt != src_fmt);
        res.pixel  = '0;
        res.nbytes = '0;
        res.format = tgt_fmt;
        res.last   = last;
        if (ok)
        begin
            case (tgt_fmt)
                FMT_I8:
                begin
                    res.pixel  = 32'(y);
                    res.nbytes = 3'd1;
                end
                FMT_AI88:
                begin
                    res.pixel  = 32'({a, y});
                    res.nbytes = 3'd2;
                end
                FMT_RGB888:
                begin
                    res.pixel  = 32'({b, g, r});
                    res.nbytes = 3'd3;
                end
                FMT_RGBA8888:
                begin
                    res.pixel  = {a, b, g, r};
                    res.nbytes = 3'd4;
                end
                FMT_RGB565:
                begin
                    res.pixel  = 32'({r[7:3], g[7:2], b[7:3]});
                    res.nbytes = 3'd2;
                end
                FMT_A8:
                begin
                    if (!has_a8)
                        ok = 1'b0;
                    res.pixel  = 32'(a);
                    res.nbytes = 3'd1;
                end
                FMT_RGBA4444:
                begin
                    res.pixel  = 32'({r[7:4], g[7:4], b[7:4], has_a8 ? a[7:4] : 4'hF});
                    res.nbytes = 3'd2;
                end
                FMT_RGB5A1:
                begin
                    res.pixel  = 32'({r[7:3], g[7:3], b[7:3], has_a8 ? a[7] : 1'b1});
                    res.nbytes = 3'd2;
                end
                default:
                begin
                    ok = 1'b0;
                end
            endcase
        end
        if (!ok)
        begin
            res.format = src_fmt;
            case (src_fmt)
                FMT_I8:
                begin
                    res.pixel  = 32'(c0);
                    res.nbytes = 3'd1;
                end
                FMT_AI88:
                begin
                    res.pixel  = 32'({c1, c0});
                    res.nbytes = 3'd2;
                end
                FMT_RGB888:
                begin
                    res.pixel  = 32'({c2, c1, c0});
                    res.nbytes = 3'd3;
                end
                default:
                begin
                    res.pixel  = {c3, c2, c1, c0};
                    res.nbytes = 3'd4;
                end
            endcase
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pixel_result_t want;
        if (!rst_n)
        begin
            src_fmt_q = SRC_FMT_RESET;
            tgt_fmt_q = TGT_FMT_RESET;
            converted_q.delete();
        end
        else
        begin
            if (src.valid && src.ready)
                converted_q.push_back(convert_pixel(src_fmt_q, tgt_fmt_q, src.chan0,
                                                    src.chan1, src.chan2, src.chan3,
                                                    src.last_in));
            if (dst.valid && dst.ready)
            begin
                if (converted_q.size() == 0)
                begin
                    $error("output beat with no pixel outstanding: pixel %h", dst.out_pixel);
                    errors++;
                end
                else
                begin
                    want = converted_q.pop_front();
                    if (dst.out_pixel !== want.pixel)
                    begin
                        $error("out_pixel: expected %h, got %h", want.pixel, dst.out_pixel);
                        errors++;
                    end
                    if (dst.out_bytes !== want.nbytes)
                    begin
                        $error("out_bytes: expected %0d, got %0d", want.nbytes, dst.out_bytes);
                        errors++;
                    end
                    if (dst.out_format !== want.format)
                    begin
                        $error("out_format: expected %0d, got %0d", want.format,
                               dst.out_format);
                        errors++;
                    end
                    if (dst.last_out !== want.last)
                    begin
                        $error("last_out: expected %b, got %b", want.last, dst.last_out);
                        errors++;
                    end
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == CFG_SRC_FMT)
                    src_fmt_q = cfg_data[SRC_FMT_W-1:0];
                else
                    tgt_fmt_q = cfg_data[TGT_FMT_W-1:0];
            end
        end
        pending    <= converted_q.size();
        fail_count <= errors;
    end

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Texture pixel format converter testbench
// Drives corner pixels and then random pixels through every source/target
// pair, with random idling on both channels and a long output hold-off;
// the pixel checker predicts and compares every converted beat.
// ----------------------------------------------------------------------------
module tb;
    import tpfc_pkg::*;

    localparam logic [TGT_FMT_W-1:0] TGT_KEEP_SRC = 4'd8;
    localparam int                   HOLD_LEN     = 40;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending;
    int                    idle_pct = 0;
    int                    stall_pct = 0;
    logic                  hold_req = 1'b0;

    logic [31:0] corner_px [8] = '{
        32'h00000000, 32'hFFFFFFFF, 32'h55AA55AA, 32'hAA55AA55,
        32'h80FF007F, 32'h7F00FF80, 32'h0102F8FC, 32'hF7F70808
    };

    tpfc_src_if src_ch ();
    tpfc_dst_if dst_ch ();

    texture_pixel_format_converter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .src       (src_ch),
        .dst       (dst_ch)
    );

    tpfc_pixel_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .src        (src_ch),
        .dst        (dst_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // output side: hold off once when asked, otherwise stall at random
    initial
    begin
        int held;
        held         = 0;
        dst_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && held < HOLD_LEN)
            begin
                dst_ch.ready <= 1'b0;
                held++;
            end
            else
                dst_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send_pixel(input logic [31:0] px, input logic last);
        while ($urandom_range(99) < idle_pct)
        begin
            src_ch.valid <= 1'b0;
            @(posedge clk);
        end
        src_ch.valid   <= 1'b1;
        src_ch.chan0   <= px[7:0];
        src_ch.chan1   <= px[15:8];
        src_ch.chan2   <= px[23:16];
        src_ch.chan3   <= px[31:24];
        src_ch.last_in <= last;
        do @(posedge clk); while (!src_ch.ready);
    endtask

    task automatic drain;
        src_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (PIPE_DEPTH + 2) @(posedge clk);
    endtask

    task automatic write_formats(input logic [SRC_FMT_W-1:0] sfmt,
                                 input logic [TGT_FMT_W-1:0] tfmt);
        logic [1:0] pad;
        pad = 2'($urandom_range(3));
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SRC_FMT;
        cfg_data  <= {pad, sfmt};
        @(posedge clk);
        cfg_index <= CFG_TGT_FMT;
        cfg_data  <= tfmt;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        int seg;
        int burst;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        src_ch.valid   = 1'b0;
        src_ch.chan0   = '0;
        src_ch.chan1   = '0;
        src_ch.chan2   = '0;
        src_ch.chan3   = '0;
        src_ch.last_in = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // corner pixels: reset formats, then two converting pairs
        for (int i = 0; i < 8; i++)
            send_pixel(corner_px[i], i[0]);
        drain;
        write_formats(FMT_RGBA8888[1:0], {1'b0, FMT_RGB5A1});
        for (int i = 0; i < 8; i++)
            send_pixel(corner_px[i], i == 7);
        drain;
        write_formats(FMT_AI88[1:0], {1'b0, FMT_A8});
        for (int i = 0; i < 8; i++)
            send_pixel(corner_px[i], i == 7);
        drain;

        // random pixels over every source/target pair
        for (int s = 0; s < 4; s++)
        begin
            for (int t = 0; t < 16; t++)
            begin
                seg = s * 16 + t;
                write_formats(SRC_FMT_W'(s), TGT_FMT_W'(t));
                case (seg % 4)
                    0:
                    begin
                        idle_pct  = 0;
                        stall_pct = 0;
                    end
                    1:
                    begin
                        idle_pct  = 74;
                        stall_pct = 0;
                    end
                    2:
                    begin
                        idle_pct  = 0;
                        stall_pct = 74;
                    end
                    default:
                    begin
                        idle_pct  = 14;
                        stall_pct = 14;
                    end
                endcase
                burst = 8;
                if (seg == 0)
                begin
                    hold_req = 1'b1;
                    burst    = 12;
                end
                for (int i = 0; i < burst; i++)
                    send_pixel($urandom, $urandom_range(7) == 0);
                drain;
            end
        end

        write_formats(SRC_FMT_RESET, TGT_KEEP_SRC);
        drain;
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

/* filelist.f */
rtl/tpfc_pkg.sv
rtl/tpfc_src_if.sv
rtl/tpfc_dst_if.sv
rtl/tpfc_luma.sv
rtl/texture_pixel_format_converter.sv
sim/tpfc_pixel_checker.sv
sim/tb.sv
